@@ sv/cffdt_pkg.sv @@
package cffdt_pkg;

    // Field widths of the byte stream and of a token.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;
    localparam int CODE_W  = 5;
    localparam int COUNT_W = 6;
    localparam int LEFT_W  = 3;
    localparam int PHASE_W = 2;

    // Default operand limit of the operand stack.
    localparam int MAX_OPERANDS_DEF = 48;

    // Packed output data width, rounded up to whole bytes.
    localparam int OUT_BITS   = VALUE_W + CODE_W + BYTE_W + COUNT_W
                                + VALUE_W + VALUE_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Parser phases.
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_INT  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_REAL = 2'd2;
    localparam logic [PHASE_W-1:0] PH_ESC  = 2'd3;

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_INT      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REAL     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OPERATOR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    // Lead bytes and limits of the DICT encoding.
    localparam logic [BYTE_W-1:0] OP_LAST      = 8'd21;
    localparam logic [BYTE_W-1:0] OP_ESCAPE    = 8'd12;
    localparam logic [BYTE_W-1:0] LEAD_SHORT   = 8'd28;
    localparam logic [BYTE_W-1:0] LEAD_LONG    = 8'd29;
    localparam logic [BYTE_W-1:0] LEAD_REAL    = 8'd30;
    localparam logic [BYTE_W-1:0] SMALL_FIRST  = 8'd32;
    localparam logic [BYTE_W-1:0] SMALL_LAST   = 8'd246;
    localparam logic [BYTE_W-1:0] POS_FIRST    = 8'd247;
    localparam logic [BYTE_W-1:0] POS_LAST     = 8'd250;
    localparam logic [BYTE_W-1:0] NEG_FIRST    = 8'd251;
    localparam logic [BYTE_W-1:0] NEG_LAST     = 8'd254;
    localparam logic [VALUE_W-1:0] SMALL_BIAS  = 32'd139;
    localparam logic [10:0]        WIDE_BIAS   = 11'd108;
    localparam logic [3:0]         REAL_END    = 4'hF;

    // Parser state kept between bytes.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [BYTE_W-1:0]  lead_byte;
        logic [VALUE_W-1:0] gathered;
        logic [LEFT_W-1:0]  bytes_left;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] newest;
        logic [VALUE_W-1:0] older;
        logic               overflow;
    } state_t;

    localparam state_t STATE_RESET = '0;

    // One completed token.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] operand_value;
        logic [CODE_W-1:0]  op_code;
        logic [BYTE_W-1:0]  op_escape;
        logic [COUNT_W-1:0] operand_count;
        logic [VALUE_W-1:0] last_operand;
        logic [VALUE_W-1:0] prior_operand;
        logic               overflow;
    } token_t;

endpackage

@@ sv/cffdt_step.sv @@
module cffdt_step #(
    parameter int MAX_OPERANDS = cffdt_pkg::MAX_OPERANDS_DEF
) (
    input  cffdt_pkg::state_t                 state,
    input  logic [cffdt_pkg::BYTE_W-1:0]      byte_in,
    input  logic                              dict_end,
    output cffdt_pkg::state_t                 state_next,
    output logic                              tok_valid,
    output cffdt_pkg::token_t                 tok
);

    localparam logic [cffdt_pkg::COUNT_W-1:0] LIMIT = cffdt_pkg::COUNT_W'(MAX_OPERANDS);

    cffdt_pkg::state_t                    work;
    logic [cffdt_pkg::VALUE_W-1:0]        g_shift;
    logic [cffdt_pkg::LEFT_W-1:0]         left_dec;
    logic [cffdt_pkg::BYTE_W-1:0]         lead_off;
    logic [10:0]                          wide_mag;
    logic [cffdt_pkg::VALUE_W-1:0]        int_value;
    logic [cffdt_pkg::VALUE_W-1:0]        small_value;
    logic                                 push;
    logic [cffdt_pkg::VALUE_W-1:0]        push_value;
    logic [cffdt_pkg::KIND_W-1:0]         push_kind;
    logic                                 oper;
    logic [cffdt_pkg::CODE_W-1:0]         oper_code;
    logic [cffdt_pkg::BYTE_W-1:0]         oper_escape;
    logic                                 at_limit;

    // Value of a multi-byte integer once its last byte is in.
    always_comb
    begin
        g_shift  = {state.gathered[cffdt_pkg::VALUE_W-9:0], byte_in};
        left_dec = (state.bytes_left != '0) ? state.bytes_left - 1'b1 : '0;
        lead_off = state.lead_byte - cffdt_pkg::POS_FIRST;
        wide_mag = {1'b0, lead_off[1:0], g_shift[7:0]} + cffdt_pkg::WIDE_BIAS;
        case (state.lead_byte) inside
            [cffdt_pkg::POS_FIRST:cffdt_pkg::POS_LAST]:
                int_value = {21'b0, wide_mag};
            [cffdt_pkg::NEG_FIRST:cffdt_pkg::NEG_LAST]:
                int_value = '0 - {21'b0, wide_mag};
            cffdt_pkg::LEAD_SHORT:
                int_value = {{16{g_shift[15]}}, g_shift[15:0]};
            default:
                int_value = g_shift;
        endcase
        small_value = {24'b0, byte_in} - cffdt_pkg::SMALL_BIAS;
    end

    // Phase decode: what the byte completes and where the parser goes.
    always_comb
    begin
        work        = state;
        push        = 1'b0;
        push_value  = '0;
        push_kind   = cffdt_pkg::KIND_INT;
        oper        = 1'b0;
        oper_code   = '0;
        oper_escape = '0;
        case (state.phase)
            cffdt_pkg::PH_INT:
            begin
                work.gathered   = g_shift;
                work.bytes_left = left_dec;
                if (left_dec == '0)
                begin
                    work.phase = cffdt_pkg::PH_IDLE;
                    push       = 1'b1;
                    push_value = int_value;
                end
            end
            cffdt_pkg::PH_REAL:
            begin
                if (byte_in[7:4] == cffdt_pkg::REAL_END || byte_in[3:0] == cffdt_pkg::REAL_END)
                begin
                    work.phase = cffdt_pkg::PH_IDLE;
                    push       = 1'b1;
                    push_kind  = cffdt_pkg::KIND_REAL;
                end
            end
            cffdt_pkg::PH_ESC:
            begin
                work.phase  = cffdt_pkg::PH_IDLE;
                oper        = 1'b1;
                oper_code   = cffdt_pkg::OP_ESCAPE[cffdt_pkg::CODE_W-1:0];
                oper_escape = byte_in;
            end
            default:
            begin
                work.phase = cffdt_pkg::PH_IDLE;
                case (byte_in) inside
                    cffdt_pkg::OP_ESCAPE:
                        work.phase = cffdt_pkg::PH_ESC;
                    [8'd0:cffdt_pkg::OP_LAST]:
                    begin
                        oper      = 1'b1;
                        oper_code = byte_in[cffdt_pkg::CODE_W-1:0];
                    end
                    [cffdt_pkg::SMALL_FIRST:cffdt_pkg::SMALL_LAST]:
                    begin
                        push       = 1'b1;
                        push_value = small_value;
                    end
                    [cffdt_pkg::POS_FIRST:cffdt_pkg::NEG_LAST]:
                    begin
                        work.phase      = cffdt_pkg::PH_INT;
                        work.lead_byte  = byte_in;
                        work.gathered   = '0;
                        work.bytes_left = 3'd1;
                    end
                    cffdt_pkg::LEAD_SHORT, cffdt_pkg::LEAD_LONG:
                    begin
                        work.phase      = cffdt_pkg::PH_INT;
                        work.lead_byte  = byte_in;
                        work.gathered   = '0;
                        work.bytes_left = (byte_in == cffdt_pkg::LEAD_SHORT) ? 3'd2 : 3'd4;
                    end
                    cffdt_pkg::LEAD_REAL:
                    begin
                        work.phase     = cffdt_pkg::PH_REAL;
                        work.lead_byte = byte_in;
                    end
                    default:
                    begin
                        push      = 1'b1;
                        push_kind = cffdt_pkg::KIND_RESERVED;
                    end
                endcase
            end
        endcase
    end

    // Operand push, operator clear, token build and end-of-dictionary reset.
    always_comb
    begin
        at_limit   = (state.count >= LIMIT);
        state_next = work;
        tok_valid  = push | oper;
        tok        = '0;
        if (push)
        begin
            state_next.count    = at_limit ? state.count : state.count + 1'b1;
            state_next.overflow = state.overflow | at_limit;
            state_next.older    = state.newest;
            state_next.newest   = push_value;
            tok.kind            = push_kind;
            tok.operand_value   = (push_kind == cffdt_pkg::KIND_INT) ? push_value : '0;
            tok.operand_count   = state_next.count;
            tok.last_operand    = push_value;
            tok.prior_operand   = state.newest;
            tok.overflow        = state_next.overflow;
        end
        else if (oper)
        begin
            tok.kind            = cffdt_pkg::KIND_OPERATOR;
            tok.op_code         = oper_code;
            tok.op_escape       = oper_escape;
            tok.operand_count   = state.count;
            tok.last_operand    = state.newest;
            tok.prior_operand   = state.older;
            tok.overflow        = state.overflow;
            state_next.count    = '0;
            state_next.overflow = 1'b0;
            state_next.newest   = '0;
            state_next.older    = '0;
        end
        if (dict_end)
        begin
            state_next = cffdt_pkg::STATE_RESET;
        end
    end

endmodule

@@ sv/cff_dict_tokenizer.sv @@
// CFF DICT tokenizer. One dictionary byte is taken per clock cycle, with no
// gaps needed between bytes: the whole parser update for a byte is a single
// registered step. A byte that completes a token (integer, real, reserved
// byte or operator) yields one result transaction; other bytes yield none.
// The output register is backed by a one-entry skid stage, so input keeps
// flowing while a result waits, and the input stalls only when both hold
// results. The tlast byte closes the dictionary and returns the operand
// count and kept operands to zero.
module cff_dict_tokenizer #(
    parameter int MAX_OPERANDS = cffdt_pkg::MAX_OPERANDS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // byte_in
    input  logic                               s_axis_tlast,  // dict_end
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // operand_value, op_code, op_escape, operand_count, last_operand,
    // prior_operand, overflow, zero fill
    output logic [cffdt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic [cffdt_pkg::KIND_W-1:0]       m_axis_tuser   // kind
);

    cffdt_pkg::state_t state_reg;
    cffdt_pkg::state_t state_next;
    cffdt_pkg::token_t tok;
    logic              tok_valid;
    logic              in_fire;
    logic              out_free;

    cffdt_pkg::token_t out_reg;
    cffdt_pkg::token_t out_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    cffdt_pkg::token_t skid_reg;
    cffdt_pkg::token_t skid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;

    cffdt_step #(
        .MAX_OPERANDS(MAX_OPERANDS)
    ) u_step (
        .state      (state_reg),
        .byte_in    (s_axis_tdata),
        .dict_end   (s_axis_tlast),
        .state_next (state_next),
        .tok_valid  (tok_valid),
        .tok        (tok)
    );

    assign s_axis_tready = ~skid_valid_reg;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~out_valid_reg | m_axis_tready;

    // Parser state advances on every input transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cffdt_pkg::STATE_RESET;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Output register and skid stage steering.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_fire && tok_valid)
            begin
                out_next       = tok;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire && tok_valid)
        begin
            skid_next       = tok;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Pack the result fields onto the output bus.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {
        {(cffdt_pkg::OUT_DATA_W - cffdt_pkg::OUT_BITS){1'b0}},
        out_reg.overflow,
        out_reg.prior_operand,
        out_reg.last_operand,
        out_reg.operand_count,
        out_reg.op_escape,
        out_reg.op_code,
        out_reg.operand_value
    };

endmodule

@@ tb/sv/cffdt_token_checker.sv @@
// Token checker for the CFF DICT tokenizer. It watches the byte and token
// channels, predicts the token for each accepted byte, and compares every
// accepted token field by field with the oldest prediction still waiting.
module cffdt_token_checker
    import cffdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [KIND_W-1:0]     m_axis_tuser,
    output int                    error_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parser state of the prediction.
    logic [PHASE_W-1:0] phase_r;
    logic [BYTE_W-1:0]  lead_r;
    logic [VALUE_W-1:0] acc_r;
    logic [LEFT_W-1:0]  left_r;
    logic [COUNT_W-1:0] depth_r;
    logic [VALUE_W-1:0] newest_r;
    logic [VALUE_W-1:0] older_r;
    logic               ovf_r;

    // Tokens predicted but not yet seen on the output.
    token_t token_q[$];

    token_t got_tok;

    initial
    begin
        error_count = 0;
        pending     = 0;
    end

    task automatic clear_parser();
        phase_r  = PH_IDLE;
        lead_r   = '0;
        acc_r    = '0;
        left_r   = '0;
        depth_r  = '0;
        newest_r = '0;
        older_r  = '0;
        ovf_r    = 1'b0;
    endtask

    // An operand enters the two-deep window; the count saturates at the limit.
    task automatic push_operand_token(input logic [KIND_W-1:0] k,
                                      input logic [VALUE_W-1:0] v);
        token_t t;
        if (depth_r < MAX_OPERANDS_DEF)
            depth_r++;
        else
            ovf_r = 1'b1;
        older_r         = newest_r;
        newest_r        = v;
        t.kind          = k;
        t.operand_value = (k == KIND_INT) ? v : '0;
        t.op_code       = '0;
        t.op_escape     = '0;
        t.operand_count = depth_r;
        t.last_operand  = newest_r;
        t.prior_operand = older_r;
        t.overflow      = ovf_r;
        token_q.push_back(t);
    endtask

    // An operator reports the gathered operands, then clears them.
    task automatic push_operator_token(input logic [BYTE_W-1:0] code,
                                       input logic [BYTE_W-1:0] esc);
        token_t t;
        t.kind          = KIND_OPERATOR;
        t.operand_value = '0;
        t.op_code       = code[CODE_W-1:0];
        t.op_escape     = esc;
        t.operand_count = depth_r;
        t.last_operand  = newest_r;
        t.prior_operand = older_r;
        t.overflow      = ovf_r;
        token_q.push_back(t);
        depth_r  = '0;
        newest_r = '0;
        older_r  = '0;
        ovf_r    = 1'b0;
    endtask

    // Advance the parser by one dictionary byte.
    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic fin);
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] lo;
        case (phase_r)
            PH_INT:
            begin
                acc_r = {acc_r[VALUE_W-BYTE_W-1:0], b};
                if (left_r != 0)
                    left_r--;
                if (left_r == 0)
                begin
                    phase_r = PH_IDLE;
                    lo = 32'(acc_r[BYTE_W-1:0]);
                    if (lead_r >= POS_FIRST && lead_r <= POS_LAST)
                        v = ((32'(lead_r) - 32'(POS_FIRST)) << 8) + lo + 32'(WIDE_BIAS);
                    else if (lead_r >= NEG_FIRST && lead_r <= NEG_LAST)
                        v = 32'd0 - ((32'(lead_r) - 32'(NEG_FIRST)) << 8) - lo
                            - 32'(WIDE_BIAS);
                    else if (lead_r == LEAD_SHORT)
                        v = {{16{acc_r[15]}}, acc_r[15:0]};
                    else
                        v = acc_r;
                    push_operand_token(KIND_INT, v);
                end
            end
            PH_REAL:
            begin
                // The real ends at the first byte that holds an end nibble.
                if (b[7:4] == REAL_END || b[3:0] == REAL_END)
                begin
                    phase_r = PH_IDLE;
                    push_operand_token(KIND_REAL, '0);
                end
            end
            PH_ESC:
            begin
                phase_r = PH_IDLE;
                push_operator_token(OP_ESCAPE, b);
            end
            default:
            begin
                if (b <= OP_LAST)
                begin
                    if (b == OP_ESCAPE)
                        phase_r = PH_ESC;
                    else
                        push_operator_token(b, '0);
                end
                else if (b >= SMALL_FIRST && b <= SMALL_LAST)
                    push_operand_token(KIND_INT, 32'(b) - SMALL_BIAS);
                else if (b >= POS_FIRST && b <= NEG_LAST)
                begin
                    phase_r = PH_INT;
                    lead_r  = b;
                    acc_r   = '0;
                    left_r  = 3'd1;
                end
                else if (b == LEAD_SHORT || b == LEAD_LONG)
                begin
                    phase_r = PH_INT;
                    lead_r  = b;
                    acc_r   = '0;
                    left_r  = (b == LEAD_SHORT) ? 3'd2 : 3'd4;
                end
                else if (b == LEAD_REAL)
                begin
                    phase_r = PH_REAL;
                    lead_r  = b;
                end
                else
                    push_operand_token(KIND_RESERVED, '0);
            end
        endcase
        // The final byte drops any partial operand and clears everything.
        if (fin)
            clear_parser();
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want_v,
                               input logic [VALUE_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    task automatic check_token(input token_t got);
        token_t want;
        if (token_q.size() == 0)
        begin
            $display("%0t: token expected none got kind %0d data %h", $time,
                     got.kind, m_axis_tdata);
            error_count++;
        end
        else
        begin
            want = token_q.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("operand_value", want.operand_value, got.operand_value);
            check_field("op_code", want.op_code, got.op_code);
            check_field("op_escape", want.op_escape, got.op_escape);
            check_field("operand_count", want.operand_count, got.operand_count);
            check_field("last_operand", want.last_operand, got.last_operand);
            check_field("prior_operand", want.prior_operand, got.prior_operand);
            check_field("overflow", want.overflow, got.overflow);
        end
    endtask

    // Tokens are checked before the byte of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            token_q.delete();
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_tok.kind = m_axis_tuser;
                {got_tok.overflow, got_tok.prior_operand, got_tok.last_operand,
                 got_tok.operand_count, got_tok.op_escape, got_tok.op_code,
                 got_tok.operand_value} = m_axis_tdata[OUT_BITS-1:0];
                check_token(got_tok);
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_byte(s_axis_tdata, s_axis_tlast);
            pending = token_q.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cffdt_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_BYTES = 1900;
    localparam int HOLD_CYCLES  = 120;
    localparam int FILL_ITEMS   = 52;

    // Byte values that the package leaves unnamed.
    localparam logic [BYTE_W-1:0] OP_FIRST = 8'd0;
    localparam logic [BYTE_W-1:0] RSV_LOW  = 8'd22;
    localparam logic [BYTE_W-1:0] RSV_ODD  = 8'd31;
    localparam logic [BYTE_W-1:0] RSV_TOP  = 8'd255;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;

    int error_count;
    int pending;
    int cycles = 0;

    // Pacing controls shared by the byte source and the token sink.
    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    bit sink_hold_req = 1'b0;

    logic [BYTE_W-1:0] dict_q[$];

    always #2 clk = ~clk;

    cff_dict_tokenizer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cffdt_token_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .pending       (pending)
    );

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one byte after a random gap and wait until it is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Stop offering bytes until every predicted token has come out.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // Append one operand of a random encoding.
    task automatic add_operand();
        int r;
        case ($urandom_range(0, 6))
            1:
            begin
                dict_q.push_back(8'($urandom_range(POS_FIRST, NEG_LAST)));
                dict_q.push_back(8'($urandom));
            end
            2:
            begin
                dict_q.push_back(LEAD_SHORT);
                repeat (2) dict_q.push_back(8'($urandom));
            end
            3:
            begin
                dict_q.push_back(LEAD_LONG);
                repeat (4) dict_q.push_back(8'($urandom));
            end
            4:
            begin
                // Real: digit bytes free of end nibbles, then the closing byte.
                dict_q.push_back(LEAD_REAL);
                repeat ($urandom_range(0, 3))
                    dict_q.push_back({4'($urandom_range(0, 14)), 4'($urandom_range(0, 14))});
                r = $urandom_range(0, 2);
                if (r == 0)
                    dict_q.push_back({REAL_END, 4'($urandom)});
                else if (r == 1)
                    dict_q.push_back({4'($urandom_range(0, 14)), REAL_END});
                else
                    dict_q.push_back({REAL_END, REAL_END});
            end
            5:
            begin
                r = $urandom_range(0, 7);
                if (r < 6)
                    dict_q.push_back(RSV_LOW + 8'(r));
                else if (r == 6)
                    dict_q.push_back(RSV_ODD);
                else
                    dict_q.push_back(RSV_TOP);
            end
            default:
                dict_q.push_back(8'($urandom_range(SMALL_FIRST, SMALL_LAST)));
        endcase
    endtask

    task automatic add_operator();
        logic [BYTE_W-1:0] code;
        code = 8'($urandom_range(OP_FIRST, OP_LAST));
        dict_q.push_back(code);
        if (code == OP_ESCAPE)
            dict_q.push_back(8'($urandom));
    endtask

    // One random dictionary: mostly operand lists closed by operators,
    // sometimes cut short, sometimes raw noise.
    task automatic send_dict(output int n_sent);
        int  n_args;
        int  cut;
        bit  close;
        dict_q.delete();
        n_sent = 0;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 12))
            begin
                send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                n_sent++;
            end
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                n_args = ($urandom_range(0, 49) == 0) ? $urandom_range(45, 55)
                                                      : $urandom_range(0, 5);
                repeat (n_args) add_operand();
                add_operator();
            end
            cut   = dict_q.size() - 1;
            close = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0)
            begin
                cut   = $urandom_range(0, dict_q.size() - 1);
                close = 1'b1;
            end
            for (int i = 0; i <= cut; i++)
                send_byte(dict_q[i], close && i == cut);
            n_sent = cut + 1;
        end
    endtask

    // Token sink: random stalls, plus one long hold-off on request.
    initial
    begin : token_sink
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (sink_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold_req = 1'b0;
            end
            stall = snk_idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Byte source and verdict.
    initial
    begin : byte_source
        int total;
        int n;
        int next_switch;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every token kind and the encoding extremes.
        send_byte(OP_FIRST, 1'b0);
        send_byte(SMALL_FIRST, 1'b0);
        send_byte(SMALL_LAST, 1'b0);
        send_byte(POS_FIRST, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(NEG_LAST, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(LEAD_SHORT, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(LEAD_LONG, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(LEAD_REAL, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(LEAD_REAL, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(RSV_LOW, 1'b0);
        send_byte(RSV_TOP, 1'b0);
        send_byte(OP_ESCAPE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(OP_LAST, 1'b0);
        // Dictionary ends inside an operand, then inside an escape pair.
        send_byte(LEAD_LONG, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(OP_ESCAPE, 1'b1);
        settle();

        // Back-pressure: the sink holds off while operands stream in
        // without gaps, enough of them to pass the operand limit.
        sink_hold_req = 1'b1;
        src_idle_on   = 1'b0;
        repeat (FILL_ITEMS) send_byte(8'($urandom_range(SMALL_FIRST, SMALL_LAST)), 1'b0);
        send_byte(OP_LAST, 1'b1);
        settle();

        // Random dictionaries, with pacing changed every few hundred bytes.
        total       = 0;
        next_switch = 0;
        while (total < RANDOM_BYTES)
        begin
            if (total >= next_switch)
            begin
                if ($urandom_range(0, 2) == 0)
                    settle();
                src_idle_on = $urandom_range(0, 1);
                snk_idle_on = $urandom_range(0, 1);
                next_switch += 250;
            end
            send_dict(n);
            total += n;
        end

        settle();
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
